[sv/ptp_pkg.sv]
// Shared types and constants of the point-triangle proximity test core.
`default_nettype none

package ptp_pkg;

    // Default coordinate width (Q8.8 at 16 bits).
    localparam int COORD_WIDTH_DEF = 16;

    // Register port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Digit width of the split multiplier and its stage count.
    localparam int MUL_DIGIT_W = 24;
    localparam int MUL_LAT     = 3;

    // Stage count of one cross product unit.
    localparam int CROSS_LAT = 2;

    typedef enum logic [1:0] {
        REG_POINT_X = 2'd0,
        REG_POINT_Y = 2'd1,
        REG_POINT_Z = 2'd2,
        REG_RADIUS  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic inside_triangle;
        logic near_plane;
        logic hit;
        logic last_result;
    } t_result;

endpackage

`default_nettype wire

[sv/point_triangle_proximity_test_core.sv]
// Top level of the point-triangle proximity test: register port, pipeline and output buffer.
//
//   channel   direction  handshake                        payload
//   triangle  in         i_valid / o_ready                i_vertex_ax .. i_vertex_cz, i_last_face
//   result    out        o_valid / i_ready                o_inside_triangle, o_near_plane, o_hit,
//                                                         o_last_result
//   config    in         psel, penable, pwrite / pready   paddr, pwdata, prdata
//
// One triangle is accepted per cycle while the output buffer is not full. The pipeline runs
// through the difference stage, the cross product stages and the two split multipliers
// (dot products, then the squared distance compare), three stages each.
// The pipeline stalls as a whole only while the two-entry output buffer is full.
// Reset is synchronous and clears the point, the radius and all valid bits.
`default_nettype none

module point_triangle_proximity_test_core #(
    parameter int COORD_WIDTH = ptp_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ptp_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [ptp_pkg::DATA_W-1:0]    pwdata,
    output logic [ptp_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,

    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_ax,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_ay,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_az,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_bx,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_by,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_bz,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_cx,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_cy,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_cz,
    input  wire logic                          i_last_face,

    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_inside_triangle,
    output logic                               o_near_plane,
    output logic                               o_hit,
    output logic                               o_last_result
);

    localparam int W        = COORD_WIDTH;
    localparam int DIFF_W   = W + 1;
    localparam int CROSS_W  = 2 * DIFF_W + 1;
    localparam int MP_W     = 2 * CROSS_W;
    localparam int DOT_W    = MP_W + 2;
    localparam int PD_W     = DIFF_W + CROSS_W + 2;
    localparam int R2_W     = 2 * W + 2;
    localparam int MUL_LAT  = ptp_pkg::MUL_LAT;
    localparam int CR_LAT   = ptp_pkg::CROSS_LAT;
    localparam int LAT      = 3 + CR_LAT + 2 * MUL_LAT;
    localparam int NUM_CR   = 6;
    localparam int NUM_MUL  = 15;
    localparam int DW_A     = ptp_pkg::DATA_W;

    // ---------------- register port ----------------
    logic signed [W-1:0] r_point_x;
    logic signed [W-1:0] r_point_y;
    logic signed [W-1:0] r_point_z;
    logic [W-1:0]        r_radius;
    logic signed [R2_W-1:0] r_radius_sq;
    ptp_pkg::t_reg_idx   reg_idx;
    logic                cfg_wr;

    assign reg_idx = ptp_pkg::t_reg_idx'(paddr[ptp_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_x <= '0;
            r_point_y <= '0;
            r_point_z <= '0;
            r_radius  <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                ptp_pkg::REG_POINT_X: r_point_x <= $signed(pwdata[W-1:0]);
                ptp_pkg::REG_POINT_Y: r_point_y <= $signed(pwdata[W-1:0]);
                ptp_pkg::REG_POINT_Z: r_point_z <= $signed(pwdata[W-1:0]);
                ptp_pkg::REG_RADIUS:  r_radius  <= pwdata[W-1:0];
                default:              r_radius  <= r_radius;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ptp_pkg::REG_POINT_X: prdata = DW_A'($unsigned(r_point_x));
            ptp_pkg::REG_POINT_Y: prdata = DW_A'($unsigned(r_point_y));
            ptp_pkg::REG_POINT_Z: prdata = DW_A'($unsigned(r_point_z));
            ptp_pkg::REG_RADIUS:  prdata = DW_A'(r_radius);
            default:              prdata = '0;
        endcase
    end

    // Change the radius only with the pipeline empty (not enforced); its square is kept ready.
    always_ff @(posedge i_clk) begin
        r_radius_sq <= $signed({1'b0, r_radius}) * $signed({1'b0, r_radius});
    end

    // ---------------- pipeline control ----------------
    logic           en;
    logic           skid_full;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_last;

    assign en      = !skid_full;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last <= {r_last[LAT-2:0], i_last_face};
        end
    end

    // ---------------- stage 1: difference vectors ----------------
    logic signed [W-1:0]      pt [3];
    logic signed [W-1:0]      va [3];
    logic signed [W-1:0]      vb [3];
    logic signed [W-1:0]      vc [3];
    logic signed [DIFF_W-1:0] r_cb [3];
    logic signed [DIFF_W-1:0] r_pb [3];
    logic signed [DIFF_W-1:0] r_ab [3];
    logic signed [DIFF_W-1:0] r_ca [3];
    logic signed [DIFF_W-1:0] r_pa [3];
    logic signed [DIFF_W-1:0] r_ba [3];
    logic signed [DIFF_W-1:0] r_pa_d [CR_LAT][3];

    assign pt[0] = r_point_x;
    assign pt[1] = r_point_y;
    assign pt[2] = r_point_z;
    assign va[0] = i_vertex_ax;
    assign va[1] = i_vertex_ay;
    assign va[2] = i_vertex_az;
    assign vb[0] = i_vertex_bx;
    assign vb[1] = i_vertex_by;
    assign vb[2] = i_vertex_bz;
    assign vc[0] = i_vertex_cx;
    assign vc[1] = i_vertex_cy;
    assign vc[2] = i_vertex_cz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_cb[k] <= DIFF_W'(vc[k]) - DIFF_W'(vb[k]);
                r_pb[k] <= DIFF_W'(pt[k]) - DIFF_W'(vb[k]);
                r_ab[k] <= DIFF_W'(va[k]) - DIFF_W'(vb[k]);
                r_ca[k] <= DIFF_W'(vc[k]) - DIFF_W'(va[k]);
                r_pa[k] <= DIFF_W'(pt[k]) - DIFF_W'(va[k]);
                r_ba[k] <= DIFF_W'(vb[k]) - DIFF_W'(va[k]);
            end
            r_pa_d[0] <= r_pa;
            for (int s = 1; s < CR_LAT; s++) begin
                r_pa_d[s] <= r_pa_d[s-1];
            end
        end
    end

    // ---------------- cross products ----------------
    // Edge b-c: (c-b)x(p-b) against (c-b)x(a-b). Edge a-c: (c-a)x(p-a) against
    // (c-a)x(b-a). Edge a-b: (b-a)x(p-a) against (b-a)x(c-a), the last being the normal.
    logic signed [DIFF_W-1:0]  cr_u [NUM_CR][3];
    logic signed [DIFF_W-1:0]  cr_v [NUM_CR][3];
    logic signed [CROSS_W-1:0] cr_c [NUM_CR][3];

    assign cr_u[0] = r_cb;
    assign cr_v[0] = r_pb;
    assign cr_u[1] = r_cb;
    assign cr_v[1] = r_ab;
    assign cr_u[2] = r_ca;
    assign cr_v[2] = r_pa;
    assign cr_u[3] = r_ca;
    assign cr_v[3] = r_ba;
    assign cr_u[4] = r_ba;
    assign cr_v[4] = r_pa;
    assign cr_u[5] = r_ba;
    assign cr_v[5] = r_ca;

    for (genvar g = 0; g < NUM_CR; g++) begin : g_cross
        ptp_cross #(
            .DIFF_W (DIFF_W)
        ) u_cross (
            .i_clk (i_clk),
            .i_en  (en),
            .i_u   (cr_u[g]),
            .i_v   (cr_v[g]),
            .o_c   (cr_c[g])
        );
    end

    // ---------------- dot product terms ----------------
    logic signed [CROSS_W-1:0] mul_a [NUM_MUL];
    logic signed [CROSS_W-1:0] mul_b [NUM_MUL];
    logic signed [MP_W-1:0]    mul_p [NUM_MUL];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mul_a[k]      = cr_c[0][k];
            mul_b[k]      = cr_c[1][k];
            mul_a[3 + k]  = cr_c[2][k];
            mul_b[3 + k]  = cr_c[3][k];
            mul_a[6 + k]  = cr_c[4][k];
            mul_b[6 + k]  = cr_c[5][k];
            mul_a[9 + k]  = cr_c[5][k];
            mul_b[9 + k]  = cr_c[5][k];
            mul_a[12 + k] = CROSS_W'(r_pa_d[CR_LAT-1][k]);
            mul_b[12 + k] = cr_c[5][k];
        end
    end

    for (genvar m = 0; m < NUM_MUL; m++) begin : g_dot
        ptp_mul #(
            .A_W (CROSS_W),
            .B_W (CROSS_W)
        ) u_mul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (mul_a[m]),
            .i_b   (mul_b[m]),
            .o_p   (mul_p[m])
        );
    end

    // ---------------- dot sums: edge signs, N.N and plane offset ----------------
    logic signed [DOT_W-1:0] dot [5];
    logic [MUL_LAT:0]        r_ins;
    logic signed [DOT_W-1:0] r_nn;
    logic signed [PD_W-1:0]  r_d;

    always_comb begin
        for (int g = 0; g < 5; g++) begin
            dot[g] = DOT_W'(mul_p[3*g]) + DOT_W'(mul_p[3*g+1]) + DOT_W'(mul_p[3*g+2]);
        end
    end

    // The inside flag rides along until the distance product is ready for the compare.
    always_ff @(posedge i_clk) begin
        if (en) begin
            // A tie on an edge (zero dot product) still counts as inside.
            r_ins[0] <= !dot[0][DOT_W-1] && !dot[1][DOT_W-1] && !dot[2][DOT_W-1];
            for (int s = 1; s <= MUL_LAT; s++) begin
                r_ins[s] <= r_ins[s-1];
            end
            r_nn <= dot[3];
            r_d  <= PD_W'(dot[4]);
        end
    end

    // ---------------- squared distance compare ----------------
    logic signed [2*PD_W-1:0]     d_sq;
    logic signed [R2_W+DOT_W-1:0] rhs;
    logic                         r_res_inside;
    logic                         r_res_near;

    ptp_mul #(
        .A_W (PD_W),
        .B_W (PD_W)
    ) u_mul_dsq (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_d),
        .i_b   (r_d),
        .o_p   (d_sq)
    );

    ptp_mul #(
        .A_W (R2_W),
        .B_W (DOT_W)
    ) u_mul_rhs (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_radius_sq),
        .i_b   (r_nn),
        .o_p   (rhs)
    );

    // A degenerate triangle has N.N of zero, so the strict compare fails there.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res_inside <= r_ins[MUL_LAT];
            r_res_near   <= d_sq < rhs;
        end
    end

    // ---------------- output buffer ----------------
    ptp_pkg::t_result res;
    ptp_pkg::t_result out_data;

    always_comb begin
        res.inside_triangle = r_res_inside;
        res.near_plane      = r_res_near;
        res.hit             = r_res_inside && r_res_near;
        res.last_result     = r_last[LAT-1];
    end

    ptp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en && r_vld[LAT-1]),
        .i_data  (res),
        .o_full  (skid_full),
        .o_valid (o_valid),
        .o_data  (out_data),
        .i_ready (i_ready)
    );

    assign o_inside_triangle = out_data.inside_triangle;
    assign o_near_plane      = out_data.near_plane;
    assign o_hit             = out_data.hit;
    assign o_last_result     = out_data.last_result;

`ifndef SYNTHESIS
    a_hit_is_and: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit == (o_inside_triangle && o_near_plane)))
        else $error("hit differs from inside and near");

    a_stall_holds_valids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_full_means_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        skid_full |-> o_valid)
        else $error("output buffer holds a spare entry without a presented result");
`endif

endmodule

`default_nettype wire

[sv/ptp_mul.sv]
// Pipelined signed multiplier built from narrow partial products over three stages.
`default_nettype none

module ptp_mul #(
    parameter int A_W = 35,
    parameter int B_W = 35
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [A_W-1:0]    i_a,
    input  wire logic signed [B_W-1:0]    i_b,
    output logic signed [A_W+B_W-1:0]     o_p
);

    localparam int DW   = ptp_pkg::MUL_DIGIT_W;
    localparam int KA   = (A_W + DW - 1) / DW;
    localparam int KB   = (B_W + DW - 1) / DW;
    localparam int AX_W = KA * DW;
    localparam int BX_W = KB * DW;
    localparam int P_W  = A_W + B_W;
    localparam int PP_W = 2 * DW + 2;

    logic signed [AX_W-1:0] a_ext;
    logic signed [BX_W-1:0] b_ext;
    logic signed [DW:0]     da [KA];
    logic signed [DW:0]     db [KB];
    logic signed [PP_W-1:0] r_pp [KA][KB];
    logic [P_W-1:0]         n_row [KA];
    logic [P_W-1:0]         r_row [KA];
    logic [P_W-1:0]         n_p;
    logic [P_W-1:0]         r_p;

    assign a_ext = AX_W'(i_a);
    assign b_ext = BX_W'(i_b);

    // Lower digits are unsigned, the top digit carries the sign.
    always_comb begin
        for (int i = 0; i < KA; i++) begin
            if (i == KA - 1) begin
                da[i] = $signed({a_ext[i*DW+DW-1], a_ext[i*DW +: DW]});
            end else begin
                da[i] = $signed({1'b0, a_ext[i*DW +: DW]});
            end
        end
        for (int j = 0; j < KB; j++) begin
            if (j == KB - 1) begin
                db[j] = $signed({b_ext[j*DW+DW-1], b_ext[j*DW +: DW]});
            end else begin
                db[j] = $signed({1'b0, b_ext[j*DW +: DW]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < KA; i++) begin
                for (int j = 0; j < KB; j++) begin
                    r_pp[i][j] <= da[i] * db[j];
                end
            end
        end
    end

    // The sums wrap modulo the product width; the exact product fits it.
    always_comb begin
        for (int i = 0; i < KA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < KB; j++) begin
                n_row[i] = n_row[i] + (P_W'(r_pp[i][j]) << (j * DW));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < KA; i++) begin
                r_row[i] <= n_row[i];
            end
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < KA; i++) begin
            n_p = n_p + (r_row[i] << (i * DW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = $signed(r_p);

endmodule

`default_nettype wire

[sv/ptp_cross.sv]
// Two-stage cross product of two signed difference vectors.
`default_nettype none

module ptp_cross #(
    parameter int DIFF_W = 17
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic signed [DIFF_W-1:0]  i_u [3],
    input  wire logic signed [DIFF_W-1:0]  i_v [3],
    output logic signed [2*DIFF_W:0]       o_c [3]
);

    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    logic signed [PROD_W-1:0]  r_p [6];
    logic signed [CROSS_W-1:0] r_c [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= i_u[1] * i_v[2];
            r_p[1] <= i_u[2] * i_v[1];
            r_p[2] <= i_u[2] * i_v[0];
            r_p[3] <= i_u[0] * i_v[2];
            r_p[4] <= i_u[0] * i_v[1];
            r_p[5] <= i_u[1] * i_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_c[k] <= CROSS_W'(r_p[2*k]) - CROSS_W'(r_p[2*k+1]);
            end
        end
    end

    assign o_c = r_c;

endmodule

`default_nettype wire

[sv/ptp_skid.sv]
// Two-entry output buffer that decouples the result channel from the pipeline.
`default_nettype none

module ptp_skid (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ptp_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output ptp_pkg::t_result      o_data,
    input  wire logic             i_ready
);

    logic             r_out_valid;
    logic             r_skid_valid;
    logic             n_out_valid;
    logic             n_skid_valid;
    ptp_pkg::t_result r_out;
    ptp_pkg::t_result r_skid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (i_ready) begin
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            n_out_valid = 1'b1;
            if (r_out_valid && !i_ready) begin
                n_skid_valid = 1'b1;
            end
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || i_ready) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire
